>>> rtl/fpsa_pkg.sv
package fpsa_pkg;

  // Fixed field widths of the request and response beats
  localparam int FUNC_W   = 2;
  localparam int PAGE_W   = 12;
  localparam int COUNT_W  = 13;
  localparam int STATUS_W = 2;
  // Width that holds the first frame of a range plus its length
  localparam int RANGE_W  = 14;

  localparam logic [PAGE_W-1:0] PAGE_MASK = 12'hfff;

  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC  = 2'd0,
    FN_FREE   = 2'd1,
    FN_REMOVE = 2'd2,
    FN_RANGE  = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    RES_OK      = 2'd0,
    RES_EMPTY   = 2'd1,
    RES_ABSENT  = 2'd2,
    RES_CLIPPED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_WAIT,
    S_HEAD_WAIT,
    S_RANGE,
    S_WALK_CHK,
    S_UNLINK_WAIT,
    S_DONE
  } state_t;

  // Flags from the shared add/compare unit
  typedef struct packed {
    logic in_range;
    logic match;
  } cmp_flags_t;

  // Finished result handed from the engine to the output register
  typedef struct packed {
    logic              valid;
    logic [PAGE_W-1:0] page_res;
    status_t           status;
  } fin_t;

endpackage

>>> rtl/fpsa_ifs.sv
interface fpsa_req_if;
  logic                         valid;
  logic                         ready;
  logic [fpsa_pkg::FUNC_W-1:0]  func;
  logic [fpsa_pkg::PAGE_W-1:0]  page;
  logic [fpsa_pkg::COUNT_W-1:0] page_count;

  modport source (output valid, func, page, page_count, input ready);
  modport sink   (input valid, func, page, page_count, output ready);
endinterface

interface fpsa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [fpsa_pkg::PAGE_W-1:0]   page_res;
  logic [fpsa_pkg::STATUS_W-1:0] status;

  modport source (output valid, page_res, status, input ready);
  modport sink   (input valid, page_res, status, output ready);
endinterface

>>> rtl/fpsa_cmp.sv
module fpsa_cmp #(
  parameter int AW        = 14,
  parameter int NUM_PAGES = 4096
) (
  input  logic [AW-1:0]          a,
  input  logic [AW-1:0]          b,
  input  logic [AW-1:0]          key,
  output logic [AW-1:0]          sum,
  output fpsa_pkg::cmp_flags_t   flags
);
  import fpsa_pkg::*;

  // One adder, a limit compare and an equality compare, shared by all steps
  always_comb begin
    sum            = a + b;
    flags.in_range = (sum < AW'(NUM_PAGES));
    flags.match    = (sum == key);
  end

endmodule

>>> rtl/fpsa_engine.sv
module fpsa_engine #(
  parameter int NUM_PAGES = 4096
) (
  input  logic           clk,
  input  logic           rst,
  fpsa_req_if.sink       req,
  input  logic           slot_free,
  output fpsa_pkg::fin_t fin
);
  import fpsa_pkg::*;

  localparam int MW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int FW = $clog2(NUM_PAGES + 1);
  localparam int AW = (FW > RANGE_W) ? FW : RANGE_W;
  localparam logic [FW-1:0] NULL_FRAME = FW'(NUM_PAGES);
  localparam logic [MW-1:0] LAST_STEP  = MW'(NUM_PAGES - 1);

  state_t             state, state_next;
  logic [FW-1:0]      head, head_next;
  logic [PAGE_W-1:0]  page_q, page_q_next;
  logic [COUNT_W-1:0] count_q, count_q_next;
  logic [COUNT_W-1:0] idx, idx_next;
  logic [MW-1:0]      prev, prev_next;
  logic [MW-1:0]      steps, steps_next;
  logic [PAGE_W-1:0]  res_q, res_q_next;
  status_t            status_q, status_q_next;

  // Link memory: one next-frame entry per frame
  logic [FW-1:0]      link_mem [NUM_PAGES];
  logic [FW-1:0]      rdata;
  logic               mem_we, mem_re;
  logic [MW-1:0]      mem_waddr, mem_raddr;
  logic [FW-1:0]      mem_wdata;

  logic [AW-1:0]      a_op, b_op, key_op, sum;
  cmp_flags_t         flags;
  logic [AW-1:0]      head_ext, page_q_ext;
  logic               acc;
  logic               done;
  status_t            done_status;

  assign head_ext   = AW'(head);
  assign page_q_ext = AW'(page_q);
  assign req.ready  = (state == S_IDLE);
  assign acc        = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= link_mem[mem_raddr];
    end
  end

  fpsa_cmp #(.AW(AW), .NUM_PAGES(NUM_PAGES)) u_cmp (
    .a     (a_op),
    .b     (b_op),
    .key   (key_op),
    .sum   (sum),
    .flags (flags)
  );

  // Operand select for the shared unit
  always_comb begin
    a_op   = '0;
    b_op   = '0;
    key_op = '0;
    unique case (state)
      S_IDLE: begin
        a_op   = AW'(req.page);
        key_op = head_ext;
      end
      S_RANGE: begin
        a_op = page_q_ext;
        b_op = AW'(idx);
      end
      S_WALK_CHK: begin
        a_op   = page_q_ext;
        key_op = AW'(rdata);
      end
      default: begin
        a_op = '0;
      end
    endcase
  end

  // Sequencer: next state, memory control and datapath updates
  always_comb begin
    state_next    = state;
    head_next     = head;
    page_q_next   = page_q;
    count_q_next  = count_q;
    idx_next      = idx;
    prev_next     = prev;
    steps_next    = steps;
    res_q_next    = res_q;
    status_q_next = status_q;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = '0;
    mem_raddr     = '0;
    mem_wdata     = head;
    done          = 1'b0;
    done_status   = RES_OK;
    fin           = '{valid: 1'b0, page_res: '0, status: RES_OK};

    unique case (state)
      S_IDLE: begin
        if (acc) begin
          page_q_next  = req.page;
          count_q_next = req.page_count;
          idx_next     = '0;
          steps_next   = '0;
          res_q_next   = '0;
          unique case (func_t'(req.func))
            FN_ALLOC: begin
              if (head == NULL_FRAME) begin
                done        = 1'b1;
                done_status = RES_EMPTY;
              end else begin
                res_q_next = head_ext[PAGE_W-1:0] & PAGE_MASK;
                mem_re     = 1'b1;
                mem_raddr  = head[MW-1:0];
                state_next = S_POP_WAIT;
              end
            end
            FN_FREE: begin
              done = 1'b1;
              if (flags.in_range) begin
                mem_we    = 1'b1;
                mem_waddr = sum[MW-1:0];
                head_next = sum[FW-1:0];
              end else begin
                done_status = RES_CLIPPED;
              end
            end
            FN_REMOVE: begin
              if (!flags.in_range || head == NULL_FRAME) begin
                done        = 1'b1;
                done_status = RES_ABSENT;
              end else if (flags.match) begin
                mem_re     = 1'b1;
                mem_raddr  = sum[MW-1:0];
                state_next = S_HEAD_WAIT;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = head[MW-1:0];
                prev_next  = head[MW-1:0];
                state_next = S_WALK_CHK;
              end
            end
            FN_RANGE: begin
              state_next = S_RANGE;
            end
          endcase
        end
      end
      S_POP_WAIT, S_HEAD_WAIT: begin
        head_next = rdata;
        done      = 1'b1;
      end
      S_RANGE: begin
        // one frame pushed per cycle, lowest first
        if (idx == count_q) begin
          done = 1'b1;
        end else if (flags.in_range) begin
          mem_we    = 1'b1;
          mem_waddr = sum[MW-1:0];
          head_next = sum[FW-1:0];
          idx_next  = idx + 1'b1;
        end else begin
          done        = 1'b1;
          done_status = RES_CLIPPED;
        end
      end
      S_WALK_CHK: begin
        // rdata is the link of prev
        if (rdata == NULL_FRAME) begin
          done        = 1'b1;
          done_status = RES_ABSENT;
        end else if (flags.match) begin
          mem_re     = 1'b1;
          mem_raddr  = page_q_ext[MW-1:0];
          state_next = S_UNLINK_WAIT;
        end else if (steps == LAST_STEP) begin
          done        = 1'b1;
          done_status = RES_ABSENT;
        end else begin
          prev_next  = rdata[MW-1:0];
          steps_next = steps + 1'b1;
          mem_re     = 1'b1;
          mem_raddr  = rdata[MW-1:0];
        end
      end
      S_UNLINK_WAIT: begin
        mem_we    = 1'b1;
        mem_waddr = prev;
        mem_wdata = rdata;
        done      = 1'b1;
      end
      S_DONE: begin
        if (slot_free) begin
          fin        = '{valid: 1'b1, page_res: res_q, status: status_q};
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Hand the result over, or park it until the output register frees
    if (done) begin
      if (slot_free) begin
        fin        = '{valid: 1'b1, page_res: res_q_next, status: done_status};
        state_next = S_IDLE;
      end else begin
        status_q_next = done_status;
        state_next    = S_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= NULL_FRAME;
    end else begin
      state <= state_next;
      head  <= head_next;
    end
  end

  always_ff @(posedge clk) begin
    page_q   <= page_q_next;
    count_q  <= count_q_next;
    idx      <= idx_next;
    prev     <= prev_next;
    steps    <= steps_next;
    res_q    <= res_q_next;
    status_q <= status_q_next;
  end

  // Checks
  a_one_port_op: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("link memory read and write in the same cycle");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && !req.valid) |=> (state == S_IDLE))
    else $error("engine left idle without a request beat");

  a_range_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_RANGE) |-> (idx <= count_q))
    else $error("range index ran past the count");

  a_fin_slot: assert property (@(posedge clk) disable iff (rst)
    fin.valid |-> slot_free)
    else $error("result handed over while the output register is full");

  a_free_push: assert property (@(posedge clk) disable iff (rst)
    (acc && func_t'(req.func) == FN_FREE && flags.in_range)
      |=> (head == $past(sum[FW-1:0])))
    else $error("freed frame did not become the head");

endmodule

>>> rtl/free_page_stack_allocator.sv
// Free-page stack allocator: a LIFO free list of NUM_PAGES frames kept as a
// head register and a link memory with one next-frame entry per frame.
// Each request beat gives exactly one response beat. Allocate makes one link
// read; free of one frame writes its link as the request is taken; remove of
// the head frame reads the head's link; remove of a deeper frame walks the
// links one by one (at most NUM_PAGES of them), then reads the frame's link
// and writes it into its predecessor; free range makes one push per frame,
// then closes once it finds the count reached, or stops early when the range
// runs off the end. Each step makes at most one access to the single-port
// link memory with registered read data. The engine takes a new request in
// the cycle after it hands a result to the output register; a result that
// cannot leave because the previous one is still unread holds the engine.
// The link memory needs no initialisation: a link is written whenever its
// frame is pushed, before it can be read. There is no double-free check.
module free_page_stack_allocator #(
  parameter int NUM_PAGES = 4096
) (
  input logic      clk,
  input logic      rst,
  fpsa_req_if.sink req,
  fpsa_rsp_if.source rsp
);
  import fpsa_pkg::*;

  fin_t              fin;
  logic              slot_free;
  logic              out_valid;
  logic [PAGE_W-1:0] out_page_res;
  status_t           out_status;

  assign slot_free    = !out_valid || rsp.ready;
  assign rsp.valid    = out_valid;
  assign rsp.page_res = out_page_res;
  assign rsp.status   = out_status;

  fpsa_engine #(.NUM_PAGES(NUM_PAGES)) u_engine (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .slot_free (slot_free),
    .fin       (fin)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin.valid) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin.valid) begin
      out_page_res <= fin.page_res;
      out_status   <= fin.status;
    end
  end

endmodule

>>> tb/tb_free_page_stack_allocator.sv
`timescale 1ns / 100ps

module tb_free_page_stack_allocator;

  import fpsa_pkg::*;

  localparam int NUM_PAGES = 4096;
  localparam int LINK_W    = PAGE_W + 1;
  localparam int COUNT_MAX = (1 << COUNT_W) - 1;
  localparam logic [LINK_W-1:0] NULL_FRAME = LINK_W'(NUM_PAGES);
  localparam int RANDOM_OPS = 1250;
  localparam int BATCH      = 8;
  localparam int HOLD_AT    = 400;
  localparam int HOLD_LEN   = 300;
  localparam int MAX_REPORTS = 100;

  typedef struct {
    func_t              func;
    logic [PAGE_W-1:0]  page;
    logic [COUNT_W-1:0] count;
  } page_op_t;

  typedef struct {
    logic [PAGE_W-1:0] page;
    status_t           status;
  } page_reply_t;

  logic clk;
  logic rst;

  fpsa_req_if req ();
  fpsa_rsp_if rsp ();

  free_page_stack_allocator #(
    .NUM_PAGES(NUM_PAGES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // Free list as the testbench sees it
  logic [LINK_W-1:0] fl_head;
  logic [LINK_W-1:0] fl_link [NUM_PAGES];

  page_op_t    pending_ops[$];
  page_reply_t awaited_replies[$];

  // Census of the free list, refreshed before each random beat group
  bit listed [NUM_PAGES];
  int listed_frames[$];

  int ops_issued   = 0;
  int ops_accepted = 0;
  int replies_seen = 0;
  int err_cnt      = 0;

  page_op_t    on_offer;
  page_reply_t want;
  int          send_wait  = 0;
  int          take_wait  = 0;
  bit          send_burst = 1'b0;
  bit          take_burst = 1'b0;
  logic        hold_off;
  int          hold_left;
  bit          hold_done;

  // Clock, 8 ns period
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Reset and quiet inputs from time zero
  initial begin
    rst            = 1'b1;
    req.valid      = 1'b0;
    req.func       = FN_ALLOC;
    req.page       = '0;
    req.page_count = '0;
    rsp.ready      = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  end

  task automatic report_mismatch(input string what);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS)
      $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic logic [LINK_W-1:0] link_of(input logic [LINK_W-1:0] frame);
    if (frame < NUM_PAGES)
      return fl_link[frame];
    return NULL_FRAME;
  endfunction

  function automatic void push_frame(input logic [LINK_W-1:0] frame);
    fl_link[frame] = fl_head;
    fl_head = frame;
  endfunction

  // Unlink one frame, head included; bounded walk copes with cycles
  function automatic status_t unlink_frame(input logic [PAGE_W-1:0] page);
    logic [LINK_W-1:0] frame;
    logic [LINK_W-1:0] prev;
    logic [LINK_W-1:0] nxt;
    frame = {1'b0, page};
    if (frame >= NUM_PAGES || fl_head == NULL_FRAME)
      return RES_ABSENT;
    if (fl_head == frame) begin
      fl_head = link_of(frame);
      return RES_OK;
    end
    prev = fl_head;
    for (int steps = 0; steps < NUM_PAGES; steps++) begin
      nxt = link_of(prev);
      if (nxt == NULL_FRAME)
        return RES_ABSENT;
      if (nxt == frame) begin
        fl_link[prev] = link_of(frame);
        return RES_OK;
      end
      prev = nxt;
    end
    return RES_ABSENT;
  endfunction

  // Apply one accepted request to the free list and queue its reply
  task automatic apply_to_free_list(input page_op_t op);
    page_reply_t r;
    int          fr;
    r.page   = '0;
    r.status = RES_OK;
    case (op.func)
      FN_ALLOC: begin
        if (fl_head == NULL_FRAME) begin
          r.status = RES_EMPTY;
        end else begin
          r.page  = fl_head[PAGE_W-1:0];
          fl_head = link_of(fl_head);
        end
      end
      FN_FREE: begin
        if (op.page < NUM_PAGES)
          push_frame({1'b0, op.page});
        else
          r.status = RES_CLIPPED;
      end
      FN_REMOVE: begin
        r.status = unlink_frame(op.page);
      end
      default: begin
        for (int i = 0; i < op.count; i++) begin
          fr = int'(op.page) + i;
          if (fr < NUM_PAGES)
            push_frame(LINK_W'(fr));
          else
            r.status = RES_CLIPPED;
        end
      end
    endcase
    awaited_replies.push_back(r);
  endtask

  task automatic push_op(input func_t func, input int page, input int count);
    page_op_t op;
    op.func  = func;
    op.page  = page[PAGE_W-1:0];
    op.count = count[COUNT_W-1:0];
    pending_ops.push_back(op);
    ops_issued++;
  endtask

  task automatic take_census();
    logic [LINK_W-1:0] f;
    int                steps;
    foreach (listed[i]) listed[i] = 1'b0;
    listed_frames.delete();
    f     = fl_head;
    steps = 0;
    while (f != NULL_FRAME && steps < NUM_PAGES) begin
      listed[f] = 1'b1;
      listed_frames.push_back(int'(f));
      f = fl_link[f];
      steps++;
    end
  endtask

  function automatic int pick_unlisted();
    int f;
    for (int tries = 0; tries < 32; tries++) begin
      f = $urandom_range(0, NUM_PAGES - 1);
      if (!listed[f])
        return f;
    end
    return -1;
  endfunction

  // One random request, biased to keep the list short but never empty for long.
  // Frames freed here are marked listed so no frame is freed twice.
  task automatic add_random_op();
    int  n;
    int  pick;
    int  f;
    int  start;
    int  cnt;
    int  span;
    bit  clear;
    int  w_alloc;
    int  w_remove;
    int  w_free;
    n = listed_frames.size();
    if (n > 120) begin
      w_alloc = 45; w_remove = 35; w_free = 15;
    end else if (n < 8) begin
      w_alloc = 15; w_remove = 10; w_free = 40;
    end else begin
      w_alloc = 30; w_remove = 20; w_free = 25;
    end
    pick = $urandom_range(0, 99);
    if (pick < w_alloc) begin
      push_op(FN_ALLOC, $urandom_range(0, NUM_PAGES - 1), $urandom_range(0, COUNT_MAX));
    end else if (pick < w_alloc + w_remove) begin
      if (n != 0 && $urandom_range(0, 99) < 65)
        f = listed_frames[$urandom_range(0, n - 1)];
      else
        f = $urandom_range(0, NUM_PAGES - 1);
      push_op(FN_REMOVE, f, $urandom_range(0, COUNT_MAX));
    end else if (pick < w_alloc + w_remove + w_free) begin
      f = pick_unlisted();
      if (f < 0) begin
        push_op(FN_ALLOC, 0, $urandom_range(0, COUNT_MAX));
      end else begin
        listed[f] = 1'b1;
        push_op(FN_FREE, f, $urandom_range(0, COUNT_MAX));
      end
    end else begin
      // long counts only near the top, so clipping keeps the run short
      if ($urandom_range(0, 4) == 0) begin
        start = NUM_PAGES - $urandom_range(1, 16);
        cnt   = $urandom_range(0, COUNT_MAX);
      end else begin
        start = $urandom_range(0, NUM_PAGES - 1);
        cnt   = $urandom_range(0, 12);
      end
      span  = (cnt < NUM_PAGES - start) ? cnt : NUM_PAGES - start;
      clear = 1'b1;
      for (int j = 0; j < span; j++)
        if (listed[start + j]) clear = 1'b0;
      if (clear) begin
        for (int j = 0; j < span; j++) listed[start + j] = 1'b1;
        push_op(FN_RANGE, start, cnt);
      end else begin
        push_op(FN_ALLOC, start, cnt);
      end
    end
  endtask

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      send_wait = 0;
    end else if (!req.valid || req.ready) begin
      if (req.valid) begin
        apply_to_free_list(on_offer);
        ops_accepted++;
        if (ops_accepted % 64 == 0)
          send_burst = ($urandom_range(0, 3) == 0);
        send_wait = send_burst ? 0 : $urandom_range(0, 3);
      end
      if (send_wait > 0) begin
        send_wait--;
        req.valid <= 1'b0;
      end else if (pending_ops.size() != 0) begin
        on_offer = pending_ops.pop_front();
        req.valid      <= 1'b1;
        req.func       <= on_offer.func;
        req.page       <= on_offer.page;
        req.page_count <= on_offer.count;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // Reply monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      take_wait = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (awaited_replies.size() == 0) begin
          report_mismatch($sformatf("reply beat with nothing outstanding (page %0h status %0d)",
                                    rsp.page_res, rsp.status));
        end else begin
          want = awaited_replies.pop_front();
          if (rsp.page_res !== want.page)
            report_mismatch($sformatf("reply %0d page_res %0h, want %0h",
                                      replies_seen, rsp.page_res, want.page));
          if (rsp.status !== want.status)
            report_mismatch($sformatf("reply %0d status %0d, want %s",
                                      replies_seen, rsp.status, want.status.name()));
        end
        replies_seen <= replies_seen + 1;
        if (replies_seen % 64 == 0)
          take_burst = ($urandom_range(0, 3) == 0);
        take_wait = take_burst ? 0 : $urandom_range(0, 3);
      end else if (take_wait > 0) begin
        take_wait--;
      end
      rsp.ready <= !hold_off && take_wait == 0;
    end
  end

  // One long hold-off on the reply side so the block backs up into its input
  always @(posedge clk) begin
    if (rst) begin
      hold_off  <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_off) begin
      if (hold_left == 1)
        hold_off <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && replies_seen >= HOLD_AT) begin
      hold_off  <= 1'b1;
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end
  end

  // Stimulus
  initial begin
    int x;
    int y;
    fl_head = NULL_FRAME;

    // directed: empty list, extremes, head/middle/tail unlink, clipping
    push_op(FN_ALLOC, 0, COUNT_MAX);
    push_op(FN_REMOVE, 0, 0);
    push_op(FN_FREE, 0, 0);
    push_op(FN_FREE, NUM_PAGES - 1, COUNT_MAX);
    push_op(FN_ALLOC, 0, 0);
    push_op(FN_ALLOC, 0, 0);
    push_op(FN_ALLOC, 0, 0);
    push_op(FN_RANGE, 10, 0);
    push_op(FN_RANGE, NUM_PAGES - 6, COUNT_MAX);
    push_op(FN_RANGE, 100, 4);
    push_op(FN_REMOVE, 103, 0);
    push_op(FN_REMOVE, NUM_PAGES - 6, 0);
    push_op(FN_REMOVE, 101, 0);
    push_op(FN_REMOVE, 101, 0);
    push_op(FN_REMOVE, 2048, 0);
    push_op(FN_FREE, 'haaa, 'h0aaa);
    push_op(FN_FREE, 'h555, 'h1555);
    push_op(FN_RANGE, 200, 1);
    push_op(FN_ALLOC, 'hfff, 0);
    push_op(FN_ALLOC, 0, 0);
    push_op(FN_ALLOC, 0, 0);
    push_op(FN_ALLOC, 0, 0);

    // random, in small groups so each group sees the current list
    while (ops_issued < 22 + RANDOM_OPS) begin
      while (ops_accepted != ops_issued) @(posedge clk);
      take_census();
      repeat (BATCH) add_random_op();
    end

    // repeated free last of all: the list becomes a self-loop for good
    while (ops_accepted != ops_issued) @(posedge clk);
    take_census();
    x = pick_unlisted();
    listed[x] = 1'b1;
    y = pick_unlisted();
    push_op(FN_FREE, x, 0);
    push_op(FN_FREE, x, 0);
    push_op(FN_ALLOC, 0, 0);
    push_op(FN_ALLOC, 0, 0);
    push_op(FN_REMOVE, y, 0);
    push_op(FN_REMOVE, x, 0);
    push_op(FN_ALLOC, 0, 0);

    while (ops_accepted != ops_issued) @(posedge clk);
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #40_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
